>>> rtl/pol_pkg.sv
// Shared types and constants for the positional ordered list.
// No dependencies; imported by every other file of the block.
package pol_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int CMD_W    = 2;
	localparam int VAL_W    = 32;
	localparam int POS_W    = 8;
	localparam int STAT_W   = 2;
	localparam int OIDX_W   = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT  = 2'd0,
		CMD_DELETE  = 2'd1,
		CMD_DISPLAY = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_BAD   = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// one write port, one read port
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [VAL_W-1:0] wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

endpackage

>>> rtl/pol_if.sv
// Valid/ready channel interfaces for command and response words.
// Depends on pol_pkg for field widths.
interface pol_cmd_if import pol_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        command;
	logic signed [VAL_W-1:0] value_in;
	logic [POS_W-1:0]        position;

	modport source (output valid, command, value_in, position, input ready);
	modport sink   (input valid, command, value_in, position, output ready);
endinterface

interface pol_rsp_if import pol_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [STAT_W-1:0]       status;
	logic signed [VAL_W-1:0] value_out;
	logic [OIDX_W-1:0]       entry_index;
	logic [OIDX_W-1:0]       entry_count;
	logic                    last;

	modport source (output valid, status, value_out, entry_index, entry_count, last,
		input ready);
	modport sink   (input valid, status, value_out, entry_index, entry_count, last,
		output ready);
endinterface

>>> rtl/pol_store.sv
// List entry memory: one write and one registered read per cycle.
// Depends on pol_pkg (mem_req_t, CAPACITY).
module pol_store import pol_pkg::*; (
	input  logic             clk,
	input  mem_req_t         req,
	output logic [VAL_W-1:0] rdata
);

	logic [VAL_W-1:0] mem_q [CAPACITY];
	logic [VAL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/pol_ctrl.sv
// Sequencer: decodes commands, runs the shift and display passes over the
// entry memory, keeps the count and the response register. Depends on pol_pkg.
module pol_ctrl import pol_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	pol_cmd_if.sink          cmd_ch,
	pol_rsp_if.source        rsp_ch,
	output mem_req_t         mreq,
	input  logic [VAL_W-1:0] rdata
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SHIFT,
		S_EMIT,
		S_RESP
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  n_q;
	logic [IDX_W-1:0]  ptr_q;
	logic [IDX_W-1:0]  ins_addr_q;
	logic              ins_q;
	logic [VAL_W-1:0]  val_q;
	status_t           stat_q;
	logic              wr_v_s1;
	logic [IDX_W-1:0]  wa_s1;

	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [VAL_W-1:0]  out_value_q;
	logic [OIDX_W-1:0] out_index_q;
	logic [OIDX_W-1:0] out_count_q;
	logic              out_last_q;

	logic              accept;
	logic              slot_free;
	logic [POS_W:0]    pos_x;
	logic [POS_W:0]    cnt_x;
	logic              ins_bad;
	logic              del_bad;
	cmd_t              cmd;

	assign cmd_ch.ready = (state_q == S_IDLE);
	assign accept       = cmd_ch.valid && cmd_ch.ready;
	assign slot_free    = !out_valid_q || rsp_ch.ready;
	assign cmd          = cmd_t'(cmd_ch.command);

	assign pos_x   = {1'b0, cmd_ch.position};
	assign cnt_x   = (POS_W + 1)'(count_q);
	assign ins_bad = (cmd_ch.position == '0) || (pos_x > cnt_x + 1'b1);
	assign del_bad = (cmd_ch.position == '0) || (pos_x > cnt_x);

	assign rsp_ch.valid       = out_valid_q;
	assign rsp_ch.status      = out_status_q;
	assign rsp_ch.value_out   = out_value_q;
	assign rsp_ch.entry_index = out_index_q;
	assign rsp_ch.entry_count = out_count_q;
	assign rsp_ch.last        = out_last_q;

	always_comb begin
		mreq       = '0;
		mreq.wdata = rdata;
		unique case (state_q)
			S_IDLE: begin
				if (accept && cmd == CMD_DISPLAY && count_q != '0) begin
					mreq.re = 1'b1;
				end
			end
			S_SHIFT: begin
				// staged move first, the new value goes in after the last move
				if (wr_v_s1) begin
					mreq.we    = 1'b1;
					mreq.waddr = wa_s1;
				end else if (n_q == '0 && ins_q) begin
					mreq.we    = 1'b1;
					mreq.waddr = ins_addr_q;
					mreq.wdata = val_q;
				end
				if (n_q != '0) begin
					mreq.re    = 1'b1;
					mreq.raddr = ptr_q;
				end
			end
			S_EMIT: begin
				if (slot_free && n_q != count_q) begin
					mreq.re    = 1'b1;
					mreq.raddr = IDX_W'(n_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			n_q          <= '0;
			ptr_q        <= '0;
			ins_addr_q   <= '0;
			ins_q        <= 1'b0;
			val_q        <= '0;
			stat_q       <= ST_OK;
			wr_v_s1      <= 1'b0;
			wa_s1        <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= '0;
			out_value_q  <= '0;
			out_index_q  <= '0;
			out_count_q  <= '0;
			out_last_q   <= 1'b0;
		end else begin
			// word held while stalled, reloaded when the emit or response step fires
			out_valid_q <= (out_valid_q && !rsp_ch.ready) ||
				(((state_q == S_EMIT) || (state_q == S_RESP)) && slot_free);
			wr_v_s1     <= (state_q == S_SHIFT) && (n_q != '0);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						val_q      <= cmd_ch.value_in;
						ins_addr_q <= IDX_W'(cmd_ch.position - 1'b1);
						unique case (cmd)
							CMD_INSERT: begin
								if (count_q == CNT_W'(CAPACITY)) begin
									stat_q  <= ST_FULL;
									state_q <= S_RESP;
								end else if (ins_bad) begin
									stat_q  <= ST_BAD;
									state_q <= S_RESP;
								end else begin
									stat_q  <= ST_OK;
									ins_q   <= 1'b1;
									n_q     <= CNT_W'(cnt_x - pos_x + 1'b1);
									ptr_q   <= IDX_W'(count_q - 1'b1);
									state_q <= S_SHIFT;
								end
							end
							CMD_DELETE: begin
								if (count_q == '0) begin
									stat_q  <= ST_EMPTY;
									state_q <= S_RESP;
								end else if (del_bad) begin
									stat_q  <= ST_BAD;
									state_q <= S_RESP;
								end else begin
									stat_q  <= ST_OK;
									ins_q   <= 1'b0;
									n_q     <= CNT_W'(cnt_x - pos_x);
									ptr_q   <= IDX_W'(cmd_ch.position);
									state_q <= S_SHIFT;
								end
							end
							CMD_DISPLAY: begin
								if (count_q == '0) begin
									stat_q  <= ST_EMPTY;
									state_q <= S_RESP;
								end else begin
									stat_q  <= ST_OK;
									n_q     <= CNT_W'(1);
									state_q <= S_EMIT;
								end
							end
							default: begin
								stat_q  <= ST_OK;
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_SHIFT: begin
					if (n_q != '0) begin
						wa_s1   <= ins_q ? ptr_q + 1'b1 : ptr_q - 1'b1;
						ptr_q   <= ins_q ? ptr_q - 1'b1 : ptr_q + 1'b1;
						n_q     <= n_q - 1'b1;
					end else if (!wr_v_s1) begin
						count_q <= ins_q ? count_q + 1'b1 : count_q - 1'b1;
						state_q <= S_RESP;
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						out_status_q <= ST_OK;
						out_value_q  <= rdata;
						out_index_q  <= OIDX_W'(n_q);
						out_count_q  <= OIDX_W'(count_q);
						out_last_q   <= (n_q == count_q);
						n_q          <= n_q + 1'b1;
						if (n_q == count_q) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_RESP: begin
					if (slot_free) begin
						out_status_q <= stat_q;
						out_value_q  <= '0;
						out_index_q  <= '0;
						out_count_q  <= OIDX_W'(count_q);
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("count above capacity");

	a_move_in_shift: assert property (@(posedge clk) disable iff (!arst_n)
		wr_v_s1 |-> state_q == S_SHIFT)
		else $error("staged move outside shift pass");

	a_no_rw_same: assert property (@(posedge clk) disable iff (!arst_n)
		!(mreq.we && mreq.re && mreq.waddr == mreq.raddr))
		else $error("read and write hit the same entry");

	a_count_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> $past(state_q) == S_SHIFT && state_q == S_RESP)
		else $error("count changed outside end of shift");

endmodule

>>> rtl/positional_ordered_list_core.sv
// Top level of the positional ordered list: entry memory plus sequencer.
// Depends on pol_pkg, pol_if, pol_store and pol_ctrl.
//
//   channel  dir  handshake     word
//   cmd_ch   in   valid/ready   command, value_in, position
//   rsp_ch   out  valid/ready   status, value_out, entry_index, entry_count, last
//
// Insert moves the entries from the position on up one per cycle, drains the staged
// move, then writes the new value; delete moves the entries behind the position down;
// display loads one word per entry in order; errors and the unused command load a
// single response word.
// Reset clears the count, not the memory. A stalled response holds the sequencer;
// the next command is taken the cycle after the last word of the previous one loads.
module positional_ordered_list_core import pol_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	pol_cmd_if.sink   cmd_ch,
	pol_rsp_if.source rsp_ch
);

	mem_req_t         mreq;
	logic [VAL_W-1:0] rdata;

	pol_store u_store (
		.clk   (clk),
		.req   (mreq),
		.rdata (rdata)
	);

	pol_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_ch),
		.rsp_ch (rsp_ch),
		.mreq   (mreq),
		.rdata  (rdata)
	);

endmodule
